[src/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg: shared definitions for the piecewise linear interpolator
// Command and status codes, register indexes, sequencer states and the
// widths of the serial multiply and divide.
// ----------------------------------------------------------------------------
package pli_pkg;

    // Default table depth.
    localparam int MAX_POINTS_DEFAULT = 32;

    // Width of the shared adder: covers the final Q15.16 sum with a
    // quotient of up to 2^40.
    localparam int ALU_W = 42;

    // Magnitudes of 33-bit differences.
    localparam int MAG_W = 33;

    // Serial multiply takes one step per multiplier bit, the divide one
    // step per product bit.
    localparam int MUL_STEPS = MAG_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Quotient is kept to 41 bits; anything larger clips to 2^40.
    localparam int QUO_W = 41;

    // Request commands.
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic REG_EXTRAPOLATE = 1'b0;
    localparam logic REG_POINTS      = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_STORED     = 2'd1,
        STATUS_ZERO_WIDTH = 2'd2,
        STATUS_SATURATED  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_WALK,
        S_CLAMP,
        S_DX,
        S_DXA,
        S_DY,
        S_DYA,
        S_EX,
        S_EXA,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

endpackage

[src/piecewise_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with linear interpolation
// Stores (x, y) breakpoints and answers queries with a saturated Q15.16
// result computed by one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// A store request writes one breakpoint and passes a status 1 result to
// the output register through S_OUT. A query at or past the second-to-last
// breakpoint takes the last segment; otherwise the search walks from the
// first breakpoint until the query no longer lies past the right end or the
// last segment is reached. A zero-width segment ends the query at S_DX. A
// result waits in S_OUT while the previous one still waits in the output
// register. The arithmetic runs on the single 42-bit adder: differences and
// magnitudes in S_DX to S_EXA, a 33-step shift-add multiply and a 66-step
// restoring divide; the search reads the table through one registered read
// port, one breakpoint per cycle. The block takes one request at a time and
// is ready again the cycle after a result is loaded; a finished result waits
// in the output register while the next request is accepted.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    // Request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [4:0]         s_point_index,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_query_x,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_y_value,
    output logic [1:0]         m_status
);

    localparam int IDXW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int AW   = pli_pkg::ALU_W;
    localparam int MW   = pli_pkg::MAG_W;
    localparam int PW   = pli_pkg::PROD_W;
    localparam int QW   = pli_pkg::QUO_W;
    localparam int CW   = pli_pkg::CNT_W;

    // Breakpoint tables.
    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];
    logic signed [31:0] x_rd_reg, y_rd_reg;
    logic [IDXW-1:0]    rd_addr;

    pli_pkg::state_t    state_reg, state_next;
    logic               ext_reg;
    logic [5:0]         npts_reg;

    logic signed [31:0] qx_reg, qx_next;
    logic signed [31:0] xl_reg, xl_next, yl_reg, yl_next;
    logic signed [31:0] xr_reg, xr_next, yr_reg, yr_next;
    logic [IDXW-1:0]    seg_reg, seg_next;
    logic [IDXW-1:0]    last_seg;
    logic [MW-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic               neg_reg, neg_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [MW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      quo_reg, quo_next;
    logic               over_reg, over_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    logic signed [31:0] res_y_reg, res_y_next;
    pli_pkg::status_t   res_st_reg, res_st_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_y_reg, m_y_next;
    pli_pkg::status_t   m_st_reg, m_st_next;

    // Shared adder.
    logic [AW-1:0]      alu_a, alu_b, alu_y;
    logic               alu_sub;

    logic               in_accept;
    logic               out_load;
    logic [MW:0]        rem_sh;
    logic [MW:0]        mul_sum;
    logic [QW-1:0]      quo_sat;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == pli_pkg::S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_y_value = m_y_reg;
    assign m_status  = m_st_reg;

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    // Index of the last segment from the clamped point count.
    always_comb begin
        if (npts_reg < 6'd2) begin
            last_seg = '0;
        end else if (int'(npts_reg) > MAX_POINTS) begin
            last_seg = IDXW'(MAX_POINTS - 2);
        end else begin
            last_seg = IDXW'(npts_reg - 6'd2);
        end
    end

    // Table write on a store request and registered read.
    always_ff @(posedge aclk) begin
        if (in_accept && s_command == pli_pkg::CMD_STORE
                && int'(s_point_index) < MAX_POINTS) begin
            x_mem[IDXW'(s_point_index)] <= s_point_x;
            y_mem[IDXW'(s_point_index)] <= s_point_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg  <= 1'b0;
            npts_reg <= 6'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pli_pkg::REG_EXTRAPOLATE: ext_reg  <= cfg_data[0];
                pli_pkg::REG_POINTS:      npts_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Sequencer state and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pli_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        qx_reg     <= qx_next;
        xl_reg     <= xl_next;
        yl_reg     <= yl_next;
        xr_reg     <= xr_next;
        yr_reg     <= yr_next;
        seg_reg    <= seg_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        over_reg   <= over_next;
        cnt_reg    <= cnt_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        m_y_reg    <= m_y_next;
        m_st_reg   <= m_st_next;
    end

    // Next state, adder operands and datapath updates.
    always_comb begin
        state_next  = state_reg;
        qx_next     = qx_reg;
        xl_next     = xl_reg;
        yl_next     = yl_reg;
        xr_next     = xr_reg;
        yr_next     = yr_reg;
        seg_next    = seg_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        over_next   = over_reg;
        cnt_next    = cnt_reg;
        res_y_next  = res_y_reg;
        res_st_next = res_st_reg;
        rd_addr     = '0;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        out_load    = 1'b0;
        rem_sh      = {rem_reg, prod_reg[PW-1]};
        mul_sum     = {1'b0, prod_reg[PW-1:MW]};
        quo_sat     = quo_reg;

        unique case (state_reg)
            pli_pkg::S_IDLE: begin
                rd_addr = last_seg;
                if (s_valid) begin
                    if (s_command == pli_pkg::CMD_STORE) begin
                        res_y_next  = '0;
                        res_st_next = pli_pkg::STATUS_STORED;
                        state_next  = pli_pkg::S_OUT;
                    end else begin
                        qx_next    = s_query_x;
                        state_next = pli_pkg::S_LAST;
                    end
                end
            end

            // At or past the second-to-last breakpoint: take the last segment.
            pli_pkg::S_LAST: begin
                if (qx_reg >= x_rd_reg) begin
                    xl_next    = x_rd_reg;
                    yl_next    = y_rd_reg;
                    seg_next   = last_seg;
                    rd_addr    = last_seg + IDXW'(1);
                    state_next = pli_pkg::S_WALK;
                end else begin
                    rd_addr    = '0;
                    state_next = pli_pkg::S_FIRST;
                end
            end

            pli_pkg::S_FIRST: begin
                xl_next    = x_rd_reg;
                yl_next    = y_rd_reg;
                seg_next   = '0;
                rd_addr    = IDXW'(1);
                state_next = pli_pkg::S_WALK;
            end

            // The read data is the right end of the current segment.
            pli_pkg::S_WALK: begin
                if (seg_reg < last_seg && qx_reg > x_rd_reg) begin
                    xl_next  = x_rd_reg;
                    yl_next  = y_rd_reg;
                    seg_next = seg_reg + IDXW'(1);
                    rd_addr  = seg_reg + IDXW'(2);
                end else begin
                    xr_next    = x_rd_reg;
                    yr_next    = y_rd_reg;
                    state_next = pli_pkg::S_CLAMP;
                end
            end

            // Without extrapolation the segment flattens outside its ends.
            pli_pkg::S_CLAMP: begin
                if (!ext_reg) begin
                    if (qx_reg < xl_reg) begin
                        yr_next = yl_reg;
                    end else if (qx_reg > xr_reg) begin
                        yl_next = yr_reg;
                    end
                end
                state_next = pli_pkg::S_DX;
            end

            pli_pkg::S_DX: begin
                alu_a   = {{10{xr_reg[31]}}, xr_reg};
                alu_b   = {{10{xl_reg[31]}}, xl_reg};
                alu_sub = 1'b1;
                dx_next = alu_y[MW-1:0];
                if (alu_y[MW-1:0] == '0) begin
                    res_y_next  = yl_reg;
                    res_st_next = pli_pkg::STATUS_ZERO_WIDTH;
                    state_next  = pli_pkg::S_OUT;
                end else begin
                    state_next = pli_pkg::S_DXA;
                end
            end

            pli_pkg::S_DXA: begin
                alu_b    = {{(AW-MW){dx_reg[MW-1]}}, dx_reg};
                alu_sub  = 1'b1;
                neg_next = dx_reg[MW-1];
                if (dx_reg[MW-1]) begin
                    dx_next = alu_y[MW-1:0];
                end
                state_next = pli_pkg::S_DY;
            end

            pli_pkg::S_DY: begin
                alu_a      = {{10{yr_reg[31]}}, yr_reg};
                alu_b      = {{10{yl_reg[31]}}, yl_reg};
                alu_sub    = 1'b1;
                dy_next    = alu_y[MW-1:0];
                state_next = pli_pkg::S_DYA;
            end

            pli_pkg::S_DYA: begin
                alu_b    = {{(AW-MW){dy_reg[MW-1]}}, dy_reg};
                alu_sub  = 1'b1;
                neg_next = neg_reg ^ dy_reg[MW-1];
                if (dy_reg[MW-1]) begin
                    dy_next = alu_y[MW-1:0];
                end
                state_next = pli_pkg::S_EX;
            end

            // The offset goes straight into the low half of the product.
            pli_pkg::S_EX: begin
                alu_a      = {{10{qx_reg[31]}}, qx_reg};
                alu_b      = {{10{xl_reg[31]}}, xl_reg};
                alu_sub    = 1'b1;
                prod_next  = {{MW{1'b0}}, alu_y[MW-1:0]};
                state_next = pli_pkg::S_EXA;
            end

            pli_pkg::S_EXA: begin
                alu_b    = {{(AW-MW){prod_reg[MW-1]}}, prod_reg[MW-1:0]};
                alu_sub  = 1'b1;
                neg_next = neg_reg ^ prod_reg[MW-1];
                if (prod_reg[MW-1]) begin
                    prod_next = {{MW{1'b0}}, alu_y[MW-1:0]};
                end
                cnt_next   = '0;
                state_next = pli_pkg::S_MUL;
            end

            // Shift-add multiply, one multiplier bit per cycle.
            pli_pkg::S_MUL: begin
                alu_a = {{(AW-MW){1'b0}}, prod_reg[PW-1:MW]};
                alu_b = {{(AW-MW){1'b0}}, dy_reg};
                if (prod_reg[0]) begin
                    mul_sum = alu_y[MW:0];
                end
                prod_next = {mul_sum, prod_reg[MW-1:1]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(pli_pkg::MUL_STEPS - 1)) begin
                    rem_next   = '0;
                    quo_next   = '0;
                    over_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = pli_pkg::S_DIV;
                end
            end

            // Restoring divide, one quotient bit per cycle.
            pli_pkg::S_DIV: begin
                alu_a     = {{(AW-MW-1){1'b0}}, rem_sh};
                alu_b     = {{(AW-MW){1'b0}}, dx_reg};
                alu_sub   = 1'b1;
                rem_next  = alu_y[AW-1] ? rem_sh[MW-1:0] : alu_y[MW-1:0];
                quo_next  = {quo_reg[QW-2:0], ~alu_y[AW-1]};
                over_next = over_reg | quo_reg[QW-1];
                prod_next = {prod_reg[PW-2:0], 1'b0};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(pli_pkg::DIV_STEPS - 1)) begin
                    state_next = pli_pkg::S_FIN;
                end
            end

            // Clip the quotient at 2^40, apply it with its sign to the left end and saturate.
            pli_pkg::S_FIN: begin
                if (over_reg || (quo_reg[QW-1] && (|quo_reg[QW-2:0]))) begin
                    quo_sat = {1'b1, {(QW-1){1'b0}}};
                end
                alu_a   = {{10{yl_reg[31]}}, yl_reg};
                alu_b   = {1'b0, quo_sat};
                alu_sub = neg_reg;
                if (alu_y[AW-1:31] == '0 || alu_y[AW-1:31] == '1) begin
                    res_y_next  = alu_y[31:0];
                    res_st_next = pli_pkg::STATUS_OK;
                end else if (!alu_y[AW-1]) begin
                    res_y_next  = 32'sh7FFF_FFFF;
                    res_st_next = pli_pkg::STATUS_SATURATED;
                end else begin
                    res_y_next  = 32'sh8000_0000;
                    res_st_next = pli_pkg::STATUS_SATURATED;
                end
                state_next = pli_pkg::S_OUT;
            end

            // Hand the result over once the output register is free.
            pli_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pli_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pli_pkg::S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_y_next     = m_y_reg;
        m_st_next    = m_st_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_y_next     = res_y_reg;
            m_st_next    = res_st_reg;
        end
    end

endmodule
